@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the masked blit block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CMB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define CMB_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/cmb_pkg.sv @@
// ----------------------------------------------------------------------------
// cmb_pkg
// Types and constants shared by the masked blit modules.
// ----------------------------------------------------------------------------
package cmb_pkg;

    localparam int DEF_VIEW_WIDTH      = 320;
    localparam int DEF_VIEW_HEIGHT     = 200;
    localparam int DEF_MAX_IMAGE_WIDTH = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int PIXEL_W   = 32;
    localparam int MASK_W    = 8;
    localparam int ADDR_W    = 19;
    localparam int ROW_W     = 11;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SOURCE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SOURCE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH      = 3'd7;

    typedef struct packed {
        logic signed [CFG_W-1:0] window_source_x;
        logic signed [CFG_W-1:0] window_source_y;
        logic signed [CFG_W-1:0] target_x;
        logic signed [CFG_W-1:0] target_y;
        logic [CFG_W-1:0]        window_width;
        logic [CFG_W-1:0]        window_height;
        logic [CFG_W-1:0]        image_width;
        logic [CFG_W-1:0]        line_pitch;
    } cmb_cfg_t;

    localparam cmb_cfg_t CFG_RESET = '{
        window_source_x: '0,
        window_source_y: '0,
        target_x:        '0,
        target_y:        '0,
        window_width:    '0,
        window_height:   '0,
        image_width:     11'd1,
        line_pitch:      11'd320
    };

    typedef struct packed {
        logic                 write_enable;
        logic [ADDR_W-1:0]    write_address;
        logic [PIXEL_W-1:0]   write_pixel;
        logic                 config_error;
    } cmb_result_t;

endpackage

@@ sv/cmb_regs.sv @@
// ----------------------------------------------------------------------------
// cmb_regs
// Configuration register file of the masked blit block.
// ----------------------------------------------------------------------------
module cmb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [cmb_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [cmb_pkg::CFG_W-1:0]         wr_data,
    output cmb_pkg::cmb_cfg_t                 cfg
);
    import cmb_pkg::*;

    cmb_cfg_t cfg_reg;
    cmb_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_WINDOW_SOURCE_X: cfg_next.window_source_x = $signed(wr_data);
                REG_WINDOW_SOURCE_Y: cfg_next.window_source_y = $signed(wr_data);
                REG_TARGET_X:        cfg_next.target_x        = $signed(wr_data);
                REG_TARGET_Y:        cfg_next.target_y        = $signed(wr_data);
                REG_WINDOW_WIDTH:    cfg_next.window_width    = wr_data;
                REG_WINDOW_HEIGHT:   cfg_next.window_height   = wr_data;
                REG_IMAGE_WIDTH:     cfg_next.image_width     = wr_data;
                REG_LINE_PITCH:      cfg_next.line_pitch      = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/cmb_counter.sv @@
// ----------------------------------------------------------------------------
// cmb_counter
// Source column and row counters with row wrap, row saturation and restart on the last pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmb_counter #(
    parameter int MAX_IMAGE_WIDTH = cmb_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic                                  last,
    input  logic [cmb_pkg::CFG_W-1:0]             image_width,
    output logic [$clog2(MAX_IMAGE_WIDTH)-1:0]    col,
    output logic [cmb_pkg::ROW_W-1:0]             row,
    output logic                                  col_in_image
);
    import cmb_pkg::*;

    localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [CMP_W-1:0] img_ext;
    logic [CMP_W-1:0] eff_width;
    logic [CMP_W-1:0] col_plus;
    logic             wrap;

    // The effective width is the register clamped to one through the maximum.
    always_comb
    begin
        img_ext = CMP_W'(image_width);
        if (img_ext == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (img_ext > CMP_W'(MAX_IMAGE_WIDTH))
        begin
            eff_width = CMP_W'(MAX_IMAGE_WIDTH);
        end
        else
        begin
            eff_width = img_ext;
        end
    end

    assign col_plus     = CMP_W'(col_reg) + CMP_W'(1);
    assign wrap         = (col_plus >= eff_width);
    assign col_in_image = (CMP_W'(col_reg) < eff_width);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (step)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                if (row_reg != ROW_MAX)
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

    `CMB_ASSERT(a_last_restarts, clk, rst_n, step && last |=> (col_reg == '0) && (row_reg == '0), "last pixel did not restart the counters")
    `CMB_ASSERT(a_row_saturates, clk, rst_n, step && !last && (row_reg == ROW_MAX) |=> (row_reg == ROW_MAX), "row counter left saturation")
    `CMB_ASSERT(a_col_steps, clk, rst_n, step && !last && !wrap |=> (col_reg == $past(col_reg) + 1'b1), "column counter did not step by one")

endmodule

@@ sv/cmb_clip.sv @@
// ----------------------------------------------------------------------------
// cmb_clip
// Window and viewport clipping, mask test, pitch check and destination address.
// ----------------------------------------------------------------------------
module cmb_clip #(
    parameter int VIEW_WIDTH      = cmb_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT     = cmb_pkg::DEF_VIEW_HEIGHT,
    parameter int OFS_W           = 14
) (
    input  cmb_pkg::cmb_cfg_t                 cfg,
    input  logic signed [OFS_W-1:0]           x,
    input  logic signed [OFS_W-1:0]           y,
    input  logic                              in_image,
    input  logic [cmb_pkg::MASK_W-1:0]        mask,
    input  logic [cmb_pkg::PIXEL_W-1:0]       pixel,
    output cmb_pkg::cmb_result_t              result
);
    import cmb_pkg::*;

    localparam int D_W    = OFS_W + 1;
    localparam int VX_W   = $clog2(VIEW_WIDTH);
    localparam int VY_W   = $clog2(VIEW_HEIGHT);
    localparam int PROD_W = VY_W + CFG_W + 1;

    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic                  in_window;
    logic                  in_view;
    logic                  err;
    logic                  we;
    logic [PROD_W-1:0]     row_base;
    logic [PROD_W-1:0]     addr_sum;

    assign dx = D_W'(cfg.target_x) + D_W'(x);
    assign dy = D_W'(cfg.target_y) + D_W'(y);

    assign in_window = (x >= 0) && (x < $signed(OFS_W'(cfg.window_width)))
                    && (y >= 0) && (y < $signed(OFS_W'(cfg.window_height)));
    assign in_view   = (dx >= 0) && (dx < $signed(D_W'(VIEW_WIDTH)))
                    && (dy >= 0) && (dy < $signed(D_W'(VIEW_HEIGHT)));

    assign err = (cfg.line_pitch < CFG_W'(VIEW_WIDTH));
    assign we  = !err && in_image && in_window && in_view && (mask != '0);

    // Inside the viewport both coordinates fit the view's index widths.
    assign row_base = PROD_W'(dy[VY_W-1:0]) * PROD_W'(cfg.line_pitch);
    assign addr_sum = row_base + PROD_W'(dx[VX_W-1:0]);

    always_comb
    begin
        result.write_enable  = we;
        result.write_address = we ? ADDR_W'(addr_sum) : '0;
        result.write_pixel   = we ? pixel : '0;
        result.config_error  = err;
    end

endmodule

@@ sv/clipped_masked_blit.sv @@
// ----------------------------------------------------------------------------
// clipped_masked_blit
// Masked, clipped copy of a streamed source image into a viewport.
// ----------------------------------------------------------------------------
// The block takes one source pixel per clock in raster order while pix_stall
// is low and returns one write request per pixel: the pixel and its source
// offsets land in an input register, then the clip and address logic (one
// 11-bit by row multiply plus add) fills the result register. Both stages move
// every cycle unless a stalled request holds them, so the sustained rate is
// one pixel per clock without output stalls. The column and row counters are
// updated once per accepted pixel. A request waiting on the output blocks the
// input register only while it already holds a pixel. Configuration writes are
// always ready and must happen while no pixel is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_masked_blit #(
    parameter int VIEW_WIDTH      = cmb_pkg::DEF_VIEW_WIDTH,
    parameter int VIEW_HEIGHT     = cmb_pkg::DEF_VIEW_HEIGHT,
    parameter int MAX_IMAGE_WIDTH = cmb_pkg::DEF_MAX_IMAGE_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pix_valid,
    output logic                              pix_stall,
    input  logic [cmb_pkg::PIXEL_W-1:0]       source_pixel,
    input  logic [cmb_pkg::MASK_W-1:0]        mask_byte,
    input  logic                              last_pixel,
    output logic                              wr_valid,
    input  logic                              wr_stall,
    output logic                              write_enable,
    output logic [cmb_pkg::ADDR_W-1:0]        write_address,
    output logic [cmb_pkg::PIXEL_W-1:0]       write_pixel,
    output logic                              config_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cmb_pkg::CFG_W-1:0]         cfg_data
);
    import cmb_pkg::*;

    localparam int COL_W = $clog2(MAX_IMAGE_WIDTH);
    localparam int OFS_W = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;

    cmb_cfg_t                cfg;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic                    col_in_image;
    logic                    pix_accept;
    logic                    wr_block;
    logic                    s1_advance;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [PIXEL_W-1:0]      s1_pixel_reg;
    logic [MASK_W-1:0]       s1_mask_reg;
    logic signed [OFS_W-1:0] s1_x_reg;
    logic signed [OFS_W-1:0] s1_y_reg;
    logic                    s1_inimg_reg;
    logic signed [OFS_W-1:0] s1_x_next;
    logic signed [OFS_W-1:0] s1_y_next;

    cmb_result_t             res_next;
    cmb_result_t             res_reg;
    logic                    wr_valid_reg;
    logic                    wr_valid_next;

    assign cfg_ready = 1'b1;

    cmb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cmb_counter #(
        .MAX_IMAGE_WIDTH (MAX_IMAGE_WIDTH)
    ) u_counter (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (pix_accept),
        .last         (last_pixel),
        .image_width  (cfg.image_width),
        .col          (col),
        .row          (row),
        .col_in_image (col_in_image)
    );

    // Handshake: the input register takes a new pixel when it is empty or its request moves on.
    assign wr_block   = wr_valid_reg && wr_stall;
    assign s1_advance = s1_valid_reg && !wr_block;
    assign pix_stall  = s1_valid_reg && wr_block;
    assign pix_accept = pix_valid && !pix_stall;

    assign s1_valid_next = pix_accept || (s1_valid_reg && !s1_advance);
    assign wr_valid_next = s1_advance || wr_block;

    // Offsets of the pixel from the window's top left corner.
    assign s1_x_next = $signed(OFS_W'(col)) - OFS_W'(cfg.window_source_x);
    assign s1_y_next = $signed(OFS_W'(row)) - OFS_W'(cfg.window_source_y);

    cmb_clip #(
        .VIEW_WIDTH      (VIEW_WIDTH),
        .VIEW_HEIGHT     (VIEW_HEIGHT),
        .OFS_W           (OFS_W)
    ) u_clip (
        .cfg      (cfg),
        .x        (s1_x_reg),
        .y        (s1_y_reg),
        .in_image (s1_inimg_reg),
        .mask     (s1_mask_reg),
        .pixel    (s1_pixel_reg),
        .result   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_pixel_reg <= source_pixel;
            s1_mask_reg  <= mask_byte;
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_inimg_reg <= col_in_image;
        end
        if (s1_advance)
        begin
            res_reg <= res_next;
        end
    end

    assign wr_valid      = wr_valid_reg;
    assign write_enable  = res_reg.write_enable;
    assign write_address = res_reg.write_address;
    assign write_pixel   = res_reg.write_pixel;
    assign config_error  = res_reg.config_error;

    `CMB_NEVER(a_no_write_on_error, clk, rst_n, wr_valid_reg && res_reg.config_error && res_reg.write_enable, "write issued with a pitch error")
    `CMB_ASSERT(a_idle_fields_zero, clk, rst_n, wr_valid_reg && !res_reg.write_enable |-> (res_reg.write_address == '0) && (res_reg.write_pixel == '0), "suppressed request carries data")
    `CMB_ASSERT(a_advance_fills_output, clk, rst_n, s1_advance |=> wr_valid_reg, "request lost between stages")

endmodule
